// ----- rtl/adaptive_breakpoint_interp_table_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros shared by the breakpoint table RTL
// Each macro expands to one labeled concurrent assertion on i_clk.
// ----------------------------------------------------------------------------
`ifndef ADAPTIVE_BREAKPOINT_INTERP_TABLE_ASSERT_SVH
`define ADAPTIVE_BREAKPOINT_INTERP_TABLE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define ABIT_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("abit assertion failed");

// next-cycle implication, checked outside reset
`define ABIT_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("abit assertion failed");

`endif

// ----- rtl/abit_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abit_pkg
// Types and constants of the adaptive breakpoint interpolation table.
// ----------------------------------------------------------------------------
package abit_pkg;

    localparam int IqW     = 24;
    localparam int PsiW    = 16;
    localparam int CfgW    = 16;
    localparam int CfgIdxW = 3;
    localparam int ProdW   = 50;
    localparam int DenW    = 25;
    localparam int DivSteps = 26;
    localparam int DivCntW = 5;

    // commands
    localparam logic [1:0] CMD_SAMPLE = 2'd0;
    localparam logic [1:0] CMD_INSERT = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    // insert status codes
    localparam logic [1:0] INS_NONE    = 2'd0;
    localparam logic [1:0] INS_APPEND  = 2'd1;
    localparam logic [1:0] INS_REPLACE = 2'd2;
    localparam logic [1:0] INS_DROP    = 2'd3;

    // configuration register indexes
    localparam logic [CfgIdxW-1:0] CFG_STABLE_BAND  = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_STABLE_NEED  = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_MIN_WIDTH    = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_NEAR_END     = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_COOLDOWN     = 3'd4;

    typedef struct packed {
        logic [1:0]            command;
        logic signed [IqW-1:0] sample_iq;
        logic signed [IqW-1:0] point_iq;
        logic signed [IqW-1:0] point_id;
        logic [PsiW-1:0]       point_psi;
        logic                  point_fixed;
    } t_in_item;

    typedef struct packed {
        logic signed [IqW-1:0] id_ref;
        logic                  id_updated;
        logic                  request_valid;
        logic [PsiW-1:0]       request_psi;
        logic signed [IqW-1:0] request_iq;
        logic [1:0]            insert_status;
        logic [5:0]            entry_count;
    } t_out_item;

    typedef struct packed {
        logic [CfgIdxW-1:0] index;
        logic [CfgW-1:0]    value;
    } t_cfg_wr;

    typedef struct packed {
        logic signed [IqW-1:0] iq;
        logic signed [IqW-1:0] id;
        logic [PsiW-1:0]       psi;
        logic                  fixed;
    } t_entry;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SLOT,
        S_POS,
        S_SHIFT,
        S_PUT,
        S_SEARCH,
        S_MUL,
        S_DSTART,
        S_DIV,
        S_FILT,
        S_DONE
    } t_state;

    // absolute difference of two currents
    function automatic logic [IqW:0] abs_diff(logic signed [IqW-1:0] a,
                                              logic signed [IqW-1:0] b);
        logic signed [IqW:0] d;
        d = {a[IqW-1], a} - {b[IqW-1], b};
        return d[IqW] ? (IqW+1)'(-d) : d;
    endfunction

endpackage

// ----- rtl/abit_chan_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abit_chan_if
// Valid/ready channel carrying one payload of type T per transfer.
// ----------------------------------------------------------------------------
interface abit_chan_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/abit_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abit_div
// Restoring divider, one quotient bit per cycle, for the interpolation weight.
// ----------------------------------------------------------------------------
module abit_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [abit_pkg::ProdW-1:0]      i_num,
    input  logic [abit_pkg::DenW-1:0]       i_den,
    output logic                            o_done,
    output logic [abit_pkg::DivSteps-1:0]   o_quo
);

    logic [abit_pkg::DenW-1:0]     r_rem;
    logic [abit_pkg::DivSteps-1:0] r_quo;
    logic [abit_pkg::DivCntW-1:0]  r_cnt;
    logic                          r_done;

    logic [abit_pkg::DenW:0]       sh;
    logic                          ge;
    logic [abit_pkg::DenW:0]       sub;

    // one trial subtraction per cycle
    always_comb begin
        sh  = {r_rem, r_quo[abit_pkg::DivSteps-1]};
        ge  = sh >= {1'b0, i_den};
        sub = sh - {1'b0, i_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= abit_pkg::DivCntW'(abit_pkg::DivSteps);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == abit_pkg::DivCntW'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    // top bits of the dividend are already below the divisor
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= abit_pkg::DenW'(i_num[abit_pkg::ProdW-1:abit_pkg::DivSteps]);
            r_quo <= i_num[abit_pkg::DivSteps-1:0];
        end else if (r_cnt != '0) begin
            r_rem <= ge ? sub[abit_pkg::DenW-1:0] : sh[abit_pkg::DenW-1:0];
            r_quo <= {r_quo[abit_pkg::DivSteps-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

// ----- rtl/adaptive_breakpoint_interp_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adaptive_breakpoint_interp_table
// Sorted breakpoint table with insert/replace, interpolation and refinement.
// ----------------------------------------------------------------------------
// One item is worked at a time; the input is ready again once the result has
// entered the output register. The table lives in a single-port-read memory
// and every walk reads one entry per cycle. A sample walks the table up to
// the first interval that brackets it, then multiplies and runs the 26-step
// divider; a zero-width interval skips the divider, and a sample with no
// bracketing interval walks all entries held. An insert walks the table to
// find its place and then moves entries where needed; on a full table a
// victim search comes first, and a point with no evictable entry is dropped.
// Clear, idle commands and samples on a table of fewer than two points go
// straight to the output register. A result still waiting in the output
// register holds the block in its last state until it is taken. No clearing
// pass is needed after reset.
// ----------------------------------------------------------------------------
module adaptive_breakpoint_interp_table #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    abit_chan_if.sink     i_cfg,
    abit_chan_if.sink     i_in,
    abit_chan_if.source   o_out
);

    `include "adaptive_breakpoint_interp_table_assert.svh"

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] DepthC = CW'(TABLE_DEPTH);

    // configuration
    logic [abit_pkg::CfgW-1:0] r_stable_band, r_stable_need, r_min_width;
    logic [abit_pkg::CfgW-1:0] r_near_end, r_cool_ival;

    // control state
    abit_pkg::t_state r_state, n_state;
    logic [CW-1:0]    r_count, n_count;
    logic signed [abit_pkg::IqW-1:0] r_prev_sample, n_prev_sample;
    logic [15:0]      r_stable_run, n_stable_run;
    logic signed [abit_pkg::IqW-1:0] r_filt, n_filt;
    logic [15:0]      r_cool, n_cool;
    logic             r_pending, n_pending;

    // item and partial results
    abit_pkg::t_in_item r_item, n_item;
    logic             r_updated, n_updated;
    logic             r_rvalid, n_rvalid;
    logic [abit_pkg::PsiW-1:0] r_rpsi, n_rpsi;
    logic signed [abit_pkg::IqW-1:0] r_riq, n_riq;
    logic [1:0]       r_status, n_status;

    // table walk
    logic [CW-1:0]    r_addr, n_addr;
    logic [CW-1:0]    r_stop, n_stop;
    logic             r_dn, n_dn;
    logic             r_iss_on, n_iss_on;
    logic             r_rd_vld, n_rd_vld;
    logic [AW-1:0]    r_rd_idx, n_rd_idx;

    // insert bookkeeping
    logic [CW-1:0]    r_slot, n_slot;
    logic             r_found, n_found;
    logic [abit_pkg::IqW:0] r_best, n_best;
    logic [CW-1:0]    r_pos, n_pos;

    // interval and arithmetic
    abit_pkg::t_entry r_pv, n_pv;
    abit_pkg::t_entry r_lo, n_lo;
    abit_pkg::t_entry r_hi, n_hi;
    logic signed [abit_pkg::ProdW-1:0] r_prod, n_prod;
    logic [abit_pkg::DivSteps-1:0] r_quo, n_quo;
    logic             r_neg, n_neg;

    // output register
    logic             r_out_valid;
    abit_pkg::t_out_item r_out;
    logic             out_load;

    // memory
    abit_pkg::t_entry mem [TABLE_DEPTH];
    abit_pkg::t_entry r_mem_q;
    logic             mem_we;
    logic [AW-1:0]    mem_wa;
    abit_pkg::t_entry mem_wd;

    // divider
    logic             div_start;
    logic [abit_pkg::ProdW-1:0] div_num;
    logic             div_done;
    logic [abit_pkg::DivSteps-1:0] div_quo;
    logic [abit_pkg::DenW-1:0] w_width;

    logic             in_xfer;
    logic [CW-1:0]    idx_ext;
    logic [abit_pkg::IqW:0] iq_gap;
    logic             take;
    logic             found_now;
    logic [CW-1:0]    pos_f;
    logic signed [abit_pkg::DenW-1:0] ds, did;
    logic signed [abit_pkg::DivSteps:0] q;
    logic signed [27:0] interp;
    logic signed [28:0] fsum;
    logic [abit_pkg::PsiW:0] psi_sum;
    abit_pkg::t_entry new_e;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = (r_state == abit_pkg::S_IDLE);
    assign in_xfer     = i_in.valid && i_in.ready;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    assign w_width = abit_pkg::DenW'(r_hi.iq) - abit_pkg::DenW'(r_lo.iq);
    assign div_num = r_prod[abit_pkg::ProdW-1] ? abit_pkg::ProdW'(-r_prod) : r_prod;

    abit_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (w_width),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // hold configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stable_band <= 16'd41;
            r_stable_need <= 16'd10;
            r_min_width   <= 16'd410;
            r_near_end    <= 16'd205;
            r_cool_ival   <= 16'd200;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.data.index)
                abit_pkg::CFG_STABLE_BAND: r_stable_band <= i_cfg.data.value;
                abit_pkg::CFG_STABLE_NEED: r_stable_need <= i_cfg.data.value;
                abit_pkg::CFG_MIN_WIDTH:   r_min_width   <= i_cfg.data.value;
                abit_pkg::CFG_NEAR_END:    r_near_end    <= i_cfg.data.value;
                abit_pkg::CFG_COOLDOWN:    r_cool_ival   <= i_cfg.data.value;
                default: ;
            endcase
        end
    end

    // table memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (r_iss_on) begin
            r_mem_q <= mem[r_addr[AW-1:0]];
        end
    end

    // next state and datapath
    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_prev_sample = r_prev_sample;
        n_stable_run  = r_stable_run;
        n_filt        = r_filt;
        n_cool        = r_cool;
        n_pending     = r_pending;
        n_item        = r_item;
        n_updated     = r_updated;
        n_rvalid      = r_rvalid;
        n_rpsi        = r_rpsi;
        n_riq         = r_riq;
        n_status      = r_status;
        n_stop        = r_stop;
        n_dn          = r_dn;
        n_slot        = r_slot;
        n_found       = r_found;
        n_best        = r_best;
        n_pos         = r_pos;
        n_pv          = r_pv;
        n_lo          = r_lo;
        n_hi          = r_hi;
        n_prod        = r_prod;
        n_quo         = r_quo;
        n_neg         = r_neg;
        mem_we        = 1'b0;
        mem_wa        = r_rd_idx;
        mem_wd        = r_mem_q;
        div_start     = 1'b0;
        out_load      = 1'b0;

        idx_ext   = CW'(r_rd_idx);
        iq_gap    = abit_pkg::abs_diff(r_mem_q.iq, r_item.point_iq);
        take      = 1'b0;
        found_now = r_found;
        pos_f     = r_pos;
        ds        = abit_pkg::DenW'(r_item.sample_iq) - abit_pkg::DenW'(r_lo.iq);
        did       = abit_pkg::DenW'(r_hi.id) - abit_pkg::DenW'(r_lo.id);
        q         = r_neg ? -$signed({1'b0, r_quo}) : $signed({1'b0, r_quo});
        interp    = 28'(r_lo.id) + 28'(q);
        fsum      = 29'(interp) + 29'(r_filt) * 29'sd3;
        psi_sum   = {1'b0, r_lo.psi} + {1'b0, r_hi.psi};
        new_e.iq    = r_item.point_iq;
        new_e.id    = r_item.point_id;
        new_e.psi   = r_item.point_psi;
        new_e.fixed = r_item.point_fixed;

        // advance the read walk
        n_iss_on = r_iss_on && (r_addr != r_stop);
        n_addr   = r_iss_on ? (r_dn ? r_addr - 1'b1 : r_addr + 1'b1) : r_addr;

        unique case (r_state)
            abit_pkg::S_IDLE: begin
                if (in_xfer) begin
                    n_item    = i_in.data;
                    n_updated = 1'b0;
                    n_rvalid  = 1'b0;
                    n_rpsi    = '0;
                    n_riq     = '0;
                    n_status  = abit_pkg::INS_NONE;
                    n_addr    = '0;
                    n_dn      = 1'b0;
                    n_state   = abit_pkg::S_DONE;
                    if (i_in.data.command == abit_pkg::CMD_INSERT) begin
                        n_pending = 1'b0;
                        n_pos     = '0;
                        if (r_count == DepthC) begin
                            n_found  = 1'b0;
                            n_stop   = DepthC - 1'b1;
                            n_iss_on = 1'b1;
                            n_state  = abit_pkg::S_SLOT;
                        end else begin
                            n_slot = r_count;
                            if (r_count == '0) begin
                                n_state = abit_pkg::S_PUT;
                            end else begin
                                n_stop   = r_count - 1'b1;
                                n_iss_on = 1'b1;
                                n_state  = abit_pkg::S_POS;
                            end
                        end
                    end else if (i_in.data.command == abit_pkg::CMD_CLEAR) begin
                        n_count = '0;
                    end else if (i_in.data.command == abit_pkg::CMD_SAMPLE &&
                                 r_count >= CW'(2)) begin
                        // update stability before walking the table
                        if (abit_pkg::abs_diff(i_in.data.sample_iq, r_prev_sample) <
                            {9'd0, r_stable_band}) begin
                            if (r_stable_run != 16'hFFFF) begin
                                n_stable_run = r_stable_run + 1'b1;
                            end
                        end else begin
                            n_stable_run = '0;
                        end
                        n_prev_sample = i_in.data.sample_iq;
                        n_stop        = r_count - 1'b1;
                        n_iss_on      = 1'b1;
                        n_state       = abit_pkg::S_SEARCH;
                    end
                end
            end

            // find the farthest evictable entry, lowest index on ties
            abit_pkg::S_SLOT: begin
                if (r_rd_vld) begin
                    take = !r_mem_q.fixed && (!r_found || iq_gap > r_best);
                    found_now = r_found || take;
                    if (take) begin
                        n_best  = iq_gap;
                        n_slot  = idx_ext;
                        n_found = 1'b1;
                    end
                    if (idx_ext == r_stop) begin
                        if (found_now) begin
                            n_addr   = '0;
                            n_stop   = DepthC - 1'b1;
                            n_dn     = 1'b0;
                            n_iss_on = 1'b1;
                            n_pos    = '0;
                            n_state  = abit_pkg::S_POS;
                        end else begin
                            n_status = abit_pkg::INS_DROP;
                            n_state  = abit_pkg::S_DONE;
                        end
                    end
                end
            end

            // count kept entries that sort ahead of the new point
            abit_pkg::S_POS: begin
                if (r_rd_vld) begin
                    if (idx_ext != r_slot &&
                        (r_mem_q.iq < r_item.point_iq ||
                         (r_mem_q.iq == r_item.point_iq && idx_ext < r_slot))) begin
                        pos_f = r_pos + 1'b1;
                    end
                    n_pos = pos_f;
                    if (idx_ext == r_stop) begin
                        n_stop = pos_f;
                        if (pos_f < r_slot) begin
                            n_addr   = r_slot - 1'b1;
                            n_dn     = 1'b1;
                            n_iss_on = 1'b1;
                            n_state  = abit_pkg::S_SHIFT;
                        end else if (pos_f > r_slot) begin
                            n_addr   = r_slot + 1'b1;
                            n_dn     = 1'b0;
                            n_iss_on = 1'b1;
                            n_state  = abit_pkg::S_SHIFT;
                        end else begin
                            n_state = abit_pkg::S_PUT;
                        end
                    end
                end
            end

            // move entries one place toward the vacated slot
            abit_pkg::S_SHIFT: begin
                if (r_rd_vld) begin
                    mem_we = 1'b1;
                    mem_wa = r_dn ? r_rd_idx + 1'b1 : r_rd_idx - 1'b1;
                    if (idx_ext == r_stop) begin
                        n_state = abit_pkg::S_PUT;
                    end
                end
            end

            abit_pkg::S_PUT: begin
                mem_we = 1'b1;
                mem_wa = r_pos[AW-1:0];
                mem_wd = new_e;
                if (r_count != DepthC) begin
                    n_count  = r_count + 1'b1;
                    n_status = abit_pkg::INS_APPEND;
                end else begin
                    n_status = abit_pkg::INS_REPLACE;
                end
                n_state = abit_pkg::S_DONE;
            end

            // first interval that brackets the sample
            abit_pkg::S_SEARCH: begin
                if (r_rd_vld) begin
                    n_pv = r_mem_q;
                    if (r_rd_idx != '0 && r_item.sample_iq >= r_pv.iq &&
                        r_item.sample_iq <= r_mem_q.iq) begin
                        n_lo     = r_pv;
                        n_hi     = r_mem_q;
                        n_iss_on = 1'b0;
                        n_state  = abit_pkg::S_MUL;
                    end else if (idx_ext == r_stop) begin
                        n_state = abit_pkg::S_DONE;
                    end
                end
            end

            abit_pkg::S_MUL: begin
                n_prod = ds * did;
                if (w_width != '0) begin
                    n_state = abit_pkg::S_DSTART;
                end else begin
                    n_quo   = '0;
                    n_neg   = 1'b0;
                    n_state = abit_pkg::S_FILT;
                end
            end

            abit_pkg::S_DSTART: begin
                div_start = 1'b1;
                n_neg     = r_prod[abit_pkg::ProdW-1];
                n_state   = abit_pkg::S_DIV;
            end

            abit_pkg::S_DIV: begin
                if (div_done) begin
                    n_quo   = div_quo;
                    n_state = abit_pkg::S_FILT;
                end
            end

            // filter and refinement request gate
            abit_pkg::S_FILT: begin
                n_filt    = fsum[abit_pkg::IqW+1:2];
                n_updated = 1'b1;
                if (r_stable_run >= r_stable_need &&
                    w_width >= {9'd0, r_min_width} &&
                    abit_pkg::abs_diff(r_lo.iq, r_item.sample_iq) >= {9'd0, r_near_end} &&
                    abit_pkg::abs_diff(r_hi.iq, r_item.sample_iq) >= {9'd0, r_near_end}) begin
                    if (r_cool != '0) begin
                        n_cool = r_cool - 1'b1;
                    end else begin
                        n_cool = r_cool_ival;
                        if (!r_pending) begin
                            n_pending = 1'b1;
                            n_rvalid  = 1'b1;
                            n_rpsi    = psi_sum[abit_pkg::PsiW:1];
                            n_riq     = r_item.sample_iq;
                        end
                        n_stable_run = '0;
                    end
                end
                n_state = abit_pkg::S_DONE;
            end

            abit_pkg::S_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    out_load = 1'b1;
                    n_state  = abit_pkg::S_IDLE;
                end
            end

            default: n_state = abit_pkg::S_IDLE;
        endcase

        // drop reads still in flight when the phase changes
        n_rd_vld = r_iss_on && (n_state == r_state);
        n_rd_idx = r_addr[AW-1:0];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= abit_pkg::S_IDLE;
            r_count       <= '0;
            r_prev_sample <= '0;
            r_stable_run  <= '0;
            r_filt        <= '0;
            r_cool        <= '0;
            r_pending     <= 1'b0;
            r_iss_on      <= 1'b0;
            r_rd_vld      <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_count       <= n_count;
            r_prev_sample <= n_prev_sample;
            r_stable_run  <= n_stable_run;
            r_filt        <= n_filt;
            r_cool        <= n_cool;
            r_pending     <= n_pending;
            r_iss_on      <= n_iss_on;
            r_rd_vld      <= n_rd_vld;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_item    <= n_item;
        r_updated <= n_updated;
        r_rvalid  <= n_rvalid;
        r_rpsi    <= n_rpsi;
        r_riq     <= n_riq;
        r_status  <= n_status;
        r_addr    <= n_addr;
        r_stop    <= n_stop;
        r_dn      <= n_dn;
        r_rd_idx  <= n_rd_idx;
        r_slot    <= n_slot;
        r_found   <= n_found;
        r_best    <= n_best;
        r_pos     <= n_pos;
        r_pv      <= n_pv;
        r_lo      <= n_lo;
        r_hi      <= n_hi;
        r_prod    <= n_prod;
        r_quo     <= n_quo;
        r_neg     <= n_neg;
        if (out_load) begin
            r_out.id_ref        <= r_filt;
            r_out.id_updated    <= r_updated;
            r_out.request_valid <= r_rvalid;
            r_out.request_psi   <= r_rpsi;
            r_out.request_iq    <= r_riq;
            r_out.insert_status <= r_status;
            r_out.entry_count   <= 6'(r_count);
        end
    end

    `ABIT_ASSERT_IMP(a_count_bound, 1'b1, r_count <= DepthC)
    `ABIT_ASSERT_NXT(a_accept_busy, i_in.valid && i_in.ready, !i_in.ready)
    `ABIT_ASSERT_IMP(a_div_nonzero, r_state == abit_pkg::S_DIV, w_width != '0)

endmodule
